### hdl/bfsp_pkg.sv
// shared constants, types and codes for the shortest path unit
// no dependencies
`timescale 1ns / 1ps

package bfsp_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_EDGES   = 1024;
  localparam int NODE_W      = 6;
  localparam int CNT_W       = 7;
  localparam int EDGE_AW     = 10;
  localparam int EDGE_CNT_W  = 11;
  localparam int WEIGHT_W    = 16;
  localparam int DIST_W      = 32;
  localparam int EDGE_WORD_W = 2 * NODE_W + WEIGHT_W;
  localparam int CFG_DATA_W  = 7;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_SOURCE     = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_TRACE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_RUN  = 2'd0,
    KIND_PATH = 2'd1,
    KIND_FULL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OSRC_FULL,
    OSRC_RUN,
    OSRC_BAD,
    OSRC_PATH
  } osrc_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FULL_OUT,
    ST_RUN_INIT,
    ST_P_START,
    ST_E_ADDR,
    ST_E_DIST,
    ST_E_ADD,
    ST_E_CMP,
    ST_RUN_OUT,
    ST_TR_CHECK,
    ST_TR_ONE,
    ST_W_TEST,
    ST_W_DATA,
    ST_O_ADDR,
    ST_O_DIST,
    ST_O_EMIT
  } state_e;

  typedef struct packed {
    logic  edge_add;
    logic  edge_clear;
    logic  latch_a;
    logic  run_init;
    logic  idx_clr;
    logic  idx_inc;
    logic  round_inc;
    logic  latch_edge;
    logic  calc;
    logic  relax;
    logic  walk_start;
    logic  walk_step;
    logic  sel_buf;
    logic  sel_nd;
    logic  latch_nd;
    logic  cnt_dec;
    logic  out_load;
    osrc_e out_src;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic in_use;
    logic pass_done;
    logic edges_empty;
    logic edge_last;
    logic trace_bad;
    logic walk_done;
    logic cnt_one;
    logic out_busy;
  } sts_t;

endpackage

### hdl/bfsp_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/bfsp_dp.sv
// datapath: config registers, edge store, distance/parent tables, path buffer
// depends on bfsp_pkg and bfsp_ram
`timescale 1ns / 1ps

module bfsp_dp import bfsp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [NODE_W-1:0]      node_a_i,
  input  logic [NODE_W-1:0]      node_b_i,
  input  logic signed [WEIGHT_W-1:0] edge_weight_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [1:0]             kind_o,
  output logic [NODE_W-1:0]      node_o,
  output logic signed [DIST_W-1:0] distance_o,
  output logic                   reachable_o,
  output logic                   negative_cycle_o,
  output logic                   last_o
);

  localparam logic [CNT_W-1:0] NODE_LIMIT = CNT_W'(MAX_NODES);
  localparam logic [EDGE_CNT_W-1:0] EDGE_LIMIT = EDGE_CNT_W'(MAX_EDGES);

  // control state
  logic [CNT_W-1:0]      node_count_q;
  logic [NODE_W-1:0]     source_q;
  logic [EDGE_CNT_W-1:0] edge_total_q;
  logic [EDGE_AW-1:0]    edge_idx_q;
  logic [CNT_W-1:0]      round_q;
  logic                  cycle_q;
  logic                  run_in_use_q;
  logic [NODE_W-1:0]     run_src_q;
  logic [MAX_NODES-1:0]  reached_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;

  // payload
  logic [NODE_W-1:0]       a_q, u_q, v_q, cur_q, nd_q;
  logic signed [DIST_W-1:0]   cand_q, dv_q;
  logic [1:0]              out_kind_q;
  logic [NODE_W-1:0]       out_node_q;
  logic signed [DIST_W-1:0] out_dist_q;
  logic                    out_reach_q, out_neg_q, out_last_q;

  logic [CNT_W-1:0]       n_w;
  logic                   check_w;
  logic [EDGE_WORD_W-1:0] e_rdata;
  logic [NODE_W-1:0]      e_from, e_to;
  logic signed [WEIGHT_W-1:0] e_w;
  logic signed [DIST_W-1:0] da_rdata, db_rdata;
  logic [NODE_W-1:0]      p_rdata, b_rdata;
  logic [NODE_W-1:0]      da_raddr;
  logic signed [DIST_W:0] sum_w;
  logic signed [DIST_W-1:0] sat_w;
  logic                   relax_ok;
  logic                   tbl_we;
  logic [NODE_W-1:0]      tbl_waddr;
  logic signed [DIST_W-1:0] dist_wdata;
  logic [NODE_W-1:0]      par_wdata;
  logic                   buf_we;
  logic [NODE_W-1:0]      buf_waddr, buf_wdata;
  logic [CNT_W-1:0]       cnt_m1;

  assign n_w     = (node_count_q > NODE_LIMIT) ? NODE_LIMIT : node_count_q;
  assign check_w = (round_q == n_w);
  assign e_from  = e_rdata[EDGE_WORD_W-1 -: NODE_W];
  assign e_to    = e_rdata[WEIGHT_W +: NODE_W];
  assign e_w     = e_rdata[WEIGHT_W-1:0];

  assign sum_w = $signed({da_rdata[DIST_W-1], da_rdata}) + (DIST_W+1)'(e_w);
  always_comb begin
    if (sum_w[DIST_W] != sum_w[DIST_W-1]) begin
      sat_w = sum_w[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      sat_w = sum_w[DIST_W-1:0];
    end
  end

  assign relax_ok = ({1'b0, u_q} < n_w) && ({1'b0, v_q} < n_w) && reached_q[u_q]
                    && (!reached_q[v_q] || (cand_q < dv_q));

  // table writes: source seeding or a relaxation
  assign tbl_we     = cmd_i.run_init ? ({1'b0, source_q} < n_w)
                                     : (cmd_i.relax && relax_ok && !check_w);
  assign tbl_waddr  = cmd_i.run_init ? source_q : v_q;
  assign dist_wdata = cmd_i.run_init ? '0 : cand_q;
  assign par_wdata  = cmd_i.run_init ? source_q : u_q;

  assign da_raddr = cmd_i.sel_buf ? b_rdata : (cmd_i.sel_nd ? nd_q : e_from);

  assign buf_we    = cmd_i.walk_start || cmd_i.walk_step;
  assign buf_waddr = cmd_i.walk_start ? '0 : cnt_q[NODE_W-1:0];
  assign buf_wdata = cmd_i.walk_start ? a_q : p_rdata;
  assign cnt_m1    = cnt_q - 1'b1;

  bfsp_ram #(.WIDTH(EDGE_WORD_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.edge_add),
    .waddr_i (edge_total_q[EDGE_AW-1:0]),
    .wdata_i ({node_a_i, node_b_i, edge_weight_i}),
    .raddr_i (edge_idx_q),
    .rdata_o (e_rdata)
  );

  // two copies of the distance table give the two read ports
  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_a_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (da_raddr),
    .rdata_o (da_rdata)
  );

  bfsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_b_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (e_to),
    .rdata_o (db_rdata)
  );

  bfsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (par_wdata),
    .raddr_i (cur_q),
    .rdata_o (p_rdata)
  );

  bfsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_path_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (cnt_m1[NODE_W-1:0]),
    .rdata_o (b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_LIMIT;
      source_q     <= NODE_W'(1);
      edge_total_q <= '0;
      edge_idx_q   <= '0;
      round_q      <= '0;
      cycle_q      <= 1'b0;
      run_in_use_q <= 1'b0;
      run_src_q    <= '0;
      reached_q    <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_NODE_COUNT) begin
          node_count_q <= cfg_data_i;
        end else begin
          source_q <= cfg_data_i[NODE_W-1:0];
        end
      end
      if (cmd_i.edge_clear) begin
        edge_total_q <= '0;
      end else if (cmd_i.edge_add) begin
        edge_total_q <= edge_total_q + 1'b1;
      end
      if (cmd_i.idx_clr) begin
        edge_idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        edge_idx_q <= edge_idx_q + 1'b1;
      end
      if (cmd_i.run_init) begin
        round_q      <= CNT_W'(1);
        cycle_q      <= 1'b0;
        run_src_q    <= source_q;
        run_in_use_q <= ({1'b0, source_q} < n_w);
        // only the source starts reached
        reached_q    <= ({1'b0, source_q} < n_w) ? (MAX_NODES'(1) << source_q) : '0;
      end else begin
        if (cmd_i.round_inc) begin
          round_q <= round_q + 1'b1;
        end
        if (cmd_i.relax && relax_ok) begin
          if (check_w) begin
            cycle_q <= 1'b1;
          end else begin
            reached_q[v_q] <= 1'b1;
          end
        end
      end
      if (cmd_i.walk_start) begin
        cnt_q <= CNT_W'(1);
      end else if (cmd_i.walk_step) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_m1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_a) begin
      a_q <= node_a_i;
    end
    if (cmd_i.latch_edge) begin
      u_q <= e_from;
      v_q <= e_to;
    end
    if (cmd_i.calc) begin
      cand_q <= sat_w;
      dv_q   <= db_rdata;
    end
    if (cmd_i.walk_start) begin
      cur_q <= a_q;
    end else if (cmd_i.walk_step) begin
      cur_q <= p_rdata;
    end
    if (cmd_i.latch_nd) begin
      nd_q <= b_rdata;
    end
    if (cmd_i.out_load) begin
      out_neg_q <= cycle_q;
      unique case (cmd_i.out_src)
        OSRC_FULL: begin
          out_kind_q  <= KIND_FULL;
          out_node_q  <= '0;
          out_dist_q  <= '0;
          out_reach_q <= 1'b0;
          out_last_q  <= 1'b1;
        end
        OSRC_RUN: begin
          out_kind_q  <= KIND_RUN;
          out_node_q  <= run_src_q;
          out_dist_q  <= '0;
          out_reach_q <= run_in_use_q;
          out_last_q  <= 1'b1;
        end
        OSRC_BAD: begin
          out_kind_q  <= KIND_PATH;
          out_node_q  <= a_q;
          out_dist_q  <= '0;
          out_reach_q <= 1'b0;
          out_last_q  <= 1'b1;
        end
        OSRC_PATH: begin
          out_kind_q  <= KIND_PATH;
          out_node_q  <= nd_q;
          out_dist_q  <= da_rdata;
          out_reach_q <= reached_q[nd_q];
          out_last_q  <= (cnt_q == CNT_W'(1));
        end
        default: begin
          out_kind_q  <= KIND_RUN;
          out_node_q  <= '0;
          out_dist_q  <= '0;
          out_reach_q <= 1'b0;
          out_last_q  <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    sts_o.full        = (edge_total_q >= EDGE_LIMIT);
    sts_o.in_use      = ({1'b0, source_q} < n_w);
    sts_o.pass_done   = (round_q > n_w);
    sts_o.edges_empty = (edge_total_q == '0);
    sts_o.edge_last   = (({1'b0, edge_idx_q} + 1'b1) == edge_total_q);
    sts_o.trace_bad   = ({1'b0, a_q} >= n_w) || !reached_q[a_q];
    sts_o.walk_done   = (cnt_q == NODE_LIMIT) || (cur_q == run_src_q);
    sts_o.cnt_one     = (cnt_q == CNT_W'(1));
    sts_o.out_busy    = out_valid_q && out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_kind_q;
  assign node_o           = out_node_q;
  assign distance_o       = out_dist_q;
  assign reachable_o      = out_reach_q;
  assign negative_cycle_o = out_neg_q;
  assign last_o           = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NODE_LIMIT) else $error("path count beyond node limit");
  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= EDGE_LIMIT) else $error("edge total beyond store size");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");
  a_cycle_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cycle_q) |-> $past(check_w && cmd_i.relax))
    else $error("negative cycle flagged outside the check pass");

endmodule

### hdl/bfsp_ctrl.sv
// controller state machine for the shortest path unit
// depends on bfsp_pkg
`timescale 1ns / 1ps

module bfsp_ctrl import bfsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  op_e    op_w;

  assign op_w = op_e'(operation_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (op_w)
            OP_CLEAR: state_d = ST_IDLE;
            OP_ADD:   state_d = sts_i.full ? ST_FULL_OUT : ST_IDLE;
            OP_RUN:   state_d = ST_RUN_INIT;
            OP_TRACE: state_d = ST_TR_CHECK;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_FULL_OUT: if (!sts_i.out_busy) state_d = ST_IDLE;
      ST_RUN_INIT: state_d = sts_i.in_use ? ST_P_START : ST_RUN_OUT;
      ST_P_START: begin
        state_d = (sts_i.pass_done || sts_i.edges_empty) ? ST_RUN_OUT : ST_E_ADDR;
      end
      ST_E_ADDR:   state_d = ST_E_DIST;
      ST_E_DIST:   state_d = ST_E_ADD;
      ST_E_ADD:    state_d = ST_E_CMP;
      ST_E_CMP:    state_d = sts_i.edge_last ? ST_P_START : ST_E_ADDR;
      ST_RUN_OUT:  if (!sts_i.out_busy) state_d = ST_IDLE;
      ST_TR_CHECK: state_d = sts_i.trace_bad ? ST_TR_ONE : ST_W_TEST;
      ST_TR_ONE:   if (!sts_i.out_busy) state_d = ST_IDLE;
      ST_W_TEST:   state_d = sts_i.walk_done ? ST_O_ADDR : ST_W_DATA;
      ST_W_DATA:   state_d = ST_W_TEST;
      ST_O_ADDR:   state_d = ST_O_DIST;
      ST_O_DIST:   state_d = ST_O_EMIT;
      ST_O_EMIT: begin
        if (!sts_i.out_busy) begin
          state_d = sts_i.cnt_one ? ST_IDLE : ST_O_ADDR;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.out_src = OSRC_FULL;
    in_stall_o    = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.edge_clear = (op_w == OP_CLEAR);
          cmd_o.edge_add   = (op_w == OP_ADD) && !sts_i.full;
          cmd_o.latch_a    = (op_w == OP_TRACE);
        end
      end
      ST_FULL_OUT: begin
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.out_src  = OSRC_FULL;
      end
      ST_RUN_INIT: cmd_o.run_init = 1'b1;
      ST_P_START:  cmd_o.idx_clr = 1'b1;
      ST_E_ADDR:   cmd_o.latch_edge = 1'b0;
      ST_E_DIST:   cmd_o.latch_edge = 1'b1;
      ST_E_ADD:    cmd_o.calc = 1'b1;
      ST_E_CMP: begin
        cmd_o.relax     = 1'b1;
        cmd_o.round_inc = sts_i.edge_last;
        cmd_o.idx_inc   = !sts_i.edge_last;
      end
      ST_RUN_OUT: begin
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.out_src  = OSRC_RUN;
      end
      ST_TR_CHECK: cmd_o.walk_start = !sts_i.trace_bad;
      ST_TR_ONE: begin
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.out_src  = OSRC_BAD;
      end
      ST_W_TEST:   cmd_o.walk_step = 1'b0;
      ST_W_DATA:   cmd_o.walk_step = 1'b1;
      ST_O_ADDR:   cmd_o.sel_nd = 1'b0;
      ST_O_DIST: begin
        cmd_o.sel_buf  = 1'b1;
        cmd_o.latch_nd = 1'b1;
      end
      ST_O_EMIT: begin
        cmd_o.sel_nd   = 1'b1;
        cmd_o.out_load = !sts_i.out_busy;
        cmd_o.cnt_dec  = !sts_i.out_busy;
        cmd_o.out_src  = OSRC_PATH;
      end
      default: cmd_o.out_load = 1'b0;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> state_q == ST_IDLE) else $error("input taken while busy");
  a_run_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN_INIT |=> (state_q == ST_P_START || state_q == ST_RUN_OUT))
    else $error("run start not followed by pass or report");
  a_emit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.relax, cmd_o.out_load, cmd_o.walk_step, cmd_o.run_init}))
    else $error("conflicting datapath commands");

endmodule

### hdl/bellman_ford_shortest_path_unit.sv
// top level of the shortest path unit: controller plus datapath
// depends on bfsp_pkg, bfsp_ctrl, bfsp_dp
//
//  channel  handshake              payload
//  in       in_valid_i/in_stall_o  operation_i node_a_i node_b_i edge_weight_i
//  out      out_valid_o/out_stall_i kind_o node_o distance_o reachable_o
//                                  negative_cycle_o last_o
//  cfg      cfg_valid_i/cfg_ready_o cfg_index_i cfg_data_i
//
// clear and add edge are taken without leaving idle; an add to a full store gives one result
// in a run each edge relaxation walks the edge store read, two distance table
// reads, a saturating add and a compare
// a trace first walks the parents into the path buffer, then reports each buffered node
// reset is asynchronous active low; no clearing pass is needed
// a stalled result holds; clear and add items are still taken behind it
`timescale 1ns / 1ps

module bellman_ford_shortest_path_unit import bfsp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 operation_i,
  input  logic [NODE_W-1:0]          node_a_i,
  input  logic [NODE_W-1:0]          node_b_i,
  input  logic signed [WEIGHT_W-1:0] edge_weight_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 kind_o,
  output logic [NODE_W-1:0]          node_o,
  output logic signed [DIST_W-1:0]   distance_o,
  output logic                       reachable_o,
  output logic                       negative_cycle_o,
  output logic                       last_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  bfsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfsp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .node_a_i         (node_a_i),
    .node_b_i         (node_b_i),
    .edge_weight_i    (edge_weight_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .kind_o           (kind_o),
    .node_o           (node_o),
    .distance_o       (distance_o),
    .reachable_o      (reachable_o),
    .negative_cycle_o (negative_cycle_o),
    .last_o           (last_o)
  );

endmodule

### tb/sv/tb_bellman_ford_shortest_path_unit.sv
// self-checking testbench for the shortest path unit: directed graphs, then random
// edge sets, runs and traces, checked against a behavioural predictor under stalls
// depends on bfsp_pkg and bellman_ford_shortest_path_unit
`timescale 1ns / 1ps

module tb_bellman_ford_shortest_path_unit;
  import bfsp_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 105;
  localparam int SETTLE       = 40;

  typedef struct {
    kind_e             kind;
    logic [5:0]        node;
    logic signed [31:0] dval;
    bit                reach;
    bit                ncyc;
    bit                last;
  } sp_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_index_i = CFG_NODE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          operation_i = OP_CLEAR;
  logic [NODE_W-1:0]   node_a_i = '0;
  logic [NODE_W-1:0]   node_b_i = '0;
  logic signed [WEIGHT_W-1:0] edge_weight_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          kind_o;
  logic [NODE_W-1:0]   node_o;
  logic signed [DIST_W-1:0] distance_o;
  logic                reachable_o;
  logic                negative_cycle_o;
  logic                last_o;

  bellman_ford_shortest_path_unit DUT (.*);

  // predictor state
  logic [5:0]         pr_from [MAX_EDGES];
  logic [5:0]         pr_to   [MAX_EDGES];
  logic signed [15:0] pr_wt   [MAX_EDGES];
  int                 pr_edges = 0;
  logic signed [31:0] pr_dist [MAX_NODES];
  bit                 pr_reached [MAX_NODES];
  logic [5:0]         pr_parent [MAX_NODES];
  bit                 pr_cycle = 0;
  int                 pr_run_src = 0;
  int                 pr_count = 64;
  int                 pr_src = 1;

  sp_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int runs_sent = 0;
  int traces_sent = 0;
  int cycles = 0;
  int burst_left = 0;
  bit hold_req = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int nodes_active();
    return (pr_count > MAX_NODES) ? MAX_NODES : pr_count;
  endfunction

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                 logic signed [15:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic bit relax_all(int n, bit apply);
    int u;
    int v;
    logic signed [31:0] cand;
    bit better;
    better = 0;
    for (int i = 0; i < pr_edges; i++) begin
      u = int'(pr_from[i]);
      v = int'(pr_to[i]);
      if (u >= n || v >= n || !pr_reached[u]) continue;
      cand = sat_sum(pr_dist[u], pr_wt[i]);
      if (!pr_reached[v] || cand < pr_dist[v]) begin
        better = 1;
        if (!apply) return 1;
        pr_dist[v] = cand;
        pr_parent[v] = u[5:0];
        pr_reached[v] = 1;
      end
    end
    return better;
  endfunction

  function automatic void push_result(kind_e k, int nd, logic signed [31:0] d, bit r,
                                      bit l);
    sp_result_t e;
    e.kind = k;
    e.node = nd[5:0];
    e.dval = d;
    e.reach = r;
    e.ncyc = pr_cycle;
    e.last = l;
    pending_results.insert(pending_results.size(), e);
  endfunction

  function automatic void shortest_path_predict(op_e op, int a, int b,
                                                logic signed [15:0] w);
    int n;
    int cur;
    int walk[$];
    bit in_use;
    n = nodes_active();
    case (op)
      OP_CLEAR: pr_edges = 0;
      OP_ADD: begin
        if (pr_edges >= MAX_EDGES) push_result(KIND_FULL, 0, 0, 0, 1);
        else begin
          pr_from[pr_edges] = a[5:0];
          pr_to[pr_edges] = b[5:0];
          pr_wt[pr_edges] = w;
          pr_edges++;
        end
      end
      OP_RUN: begin
        in_use = pr_src < n;
        for (int i = 0; i < MAX_NODES; i++) pr_reached[i] = 0;
        pr_cycle = 0;
        pr_run_src = pr_src;
        if (in_use) begin
          pr_reached[pr_src] = 1;
          pr_dist[pr_src] = 0;
          pr_parent[pr_src] = pr_src[5:0];
          for (int r = 1; r < n; r++) void'(relax_all(n, 1));
          pr_cycle = relax_all(n, 0);
        end
        push_result(KIND_RUN, pr_src, 0, in_use, 1);
      end
      default: begin
        if (a >= n || !pr_reached[a]) push_result(KIND_PATH, a, 0, 0, 1);
        else begin
          cur = a;
          walk.insert(walk.size(), cur);
          while (walk.size() < MAX_NODES && cur != pr_run_src) begin
            cur = int'(pr_parent[cur]);
            walk.insert(walk.size(), cur);
          end
          for (int k = walk.size() - 1; k >= 0; k--)
            push_result(KIND_PATH, walk[k], pr_dist[walk[k]], pr_reached[walk[k]],
                        k == 0);
        end
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    sp_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d node %0d dist %0d", kind_o, node_o,
                   distance_o);
      end else begin
        e = pending_results.pop_front();
        if (kind_o !== e.kind || node_o !== e.node || distance_o !== e.dval ||
            reachable_o !== e.reach || negative_cycle_o !== e.ncyc || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp kind %0d node %0d dist %0d reach %0d ncyc %0d ",
                      "last %0d, got %0d %0d %0d %0d %0d %0d"},
                     e.kind, e.node, e.dval, e.reach, e.ncyc, e.last, kind_o, node_o,
                     distance_o, reachable_o, negative_cycle_o, last_o);
        end
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin
    int mode;
    int phase_left;
    int hold_left;
    mode = 0;
    phase_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (phase_left == 0) begin
        mode = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else begin
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(0, 9) < 3);
          2: out_stall_i = ($urandom_range(0, 9) < 7);
          default: out_stall_i = (phase_left % 4 == 0);
        endcase
      end
    end
  end

  task automatic send_item(op_e op, int a, int b, int w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = op;
    node_a_i = a[5:0];
    node_b_i = b[5:0];
    edge_weight_i = w[15:0];
    do @(posedge clk_i); while (in_stall_o);
    shortest_path_predict(op, a, b, w[15:0]);
    items_sent++;
    if (op == OP_RUN) runs_sent++;
    if (op == OP_TRACE) traces_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, int data);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data[CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_NODE_COUNT) pr_count = data & 127;
    else pr_src = data & 63;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_trace_before_run();
    send_item(OP_TRACE, 5, 0, 0);
    send_item(OP_TRACE, 63, 63, -1);
  endtask

  task automatic test_small_graph();
    cfg_write(CFG_NODE_COUNT, 6);
    cfg_write(CFG_SOURCE, 0);
    send_item(OP_ADD, 0, 1, 5);
    send_item(OP_ADD, 1, 2, -3);
    send_item(OP_ADD, 0, 2, 10);
    send_item(OP_ADD, 2, 3, 32767);
    send_item(OP_ADD, 3, 4, -32768);
    send_item(OP_ADD, 4, 4, 0);
    send_item(OP_ADD, 4, 7, 1);
    send_item(OP_ADD, 63, 5, 1);
    send_item(OP_RUN, 0, 0, 0);
    for (int i = 0; i < 6; i++) send_item(OP_TRACE, i, 0, 0);
    send_item(OP_TRACE, 63, 0, 0);
  endtask

  task automatic test_negative_cycle();
    send_item(OP_CLEAR, 0, 0, 0);
    cfg_write(CFG_NODE_COUNT, 4);
    send_item(OP_ADD, 0, 1, 1);
    send_item(OP_ADD, 1, 2, -5);
    send_item(OP_ADD, 2, 1, 2);
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_TRACE, 2, 0, 0);
    send_item(OP_TRACE, 3, 0, 0);
  endtask

  task automatic test_source_cases();
    // source outside the nodes in use reaches nothing
    cfg_write(CFG_SOURCE, 5);
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_TRACE, 0, 0, 0);
    // traces keep using the source latched at the last run
    cfg_write(CFG_SOURCE, 0);
    send_item(OP_RUN, 0, 0, 0);
    cfg_write(CFG_SOURCE, 2);
    send_item(OP_TRACE, 3, 0, 0);
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_TRACE, 3, 0, 0);
  endtask

  task automatic test_node_count_extremes();
    send_item(OP_CLEAR, 0, 0, 0);
    send_item(OP_ADD, 63, 0, 7);
    send_item(OP_ADD, 0, 62, -2);
    send_item(OP_ADD, 62, 63, 3);
    cfg_write(CFG_NODE_COUNT, 0);
    send_item(OP_RUN, 0, 0, 0);
    cfg_write(CFG_NODE_COUNT, 127);
    cfg_write(CFG_SOURCE, 63);
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_TRACE, 62, 0, 0);
    cfg_write(CFG_NODE_COUNT, 64);
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_TRACE, 0, 0, 0);
    cfg_write(CFG_NODE_COUNT, 1);
    cfg_write(CFG_SOURCE, 0);
    send_item(OP_RUN, 0, 0, 0);
    send_item(OP_TRACE, 0, 0, 0);
  endtask

  task automatic test_output_backpressure();
    cfg_write(CFG_NODE_COUNT, 10);
    cfg_write(CFG_SOURCE, 0);
    for (int i = 0; i < 9; i++) send_item(OP_ADD, i, i + 1, $urandom_range(0, 50));
    send_item(OP_RUN, 0, 0, 0);
    wait_idle();
    hold_req = 1;
    // a result is held behind the hold, so the input stalls
    for (int i = 0; i < 10; i++) send_item(OP_TRACE, 9 - (i % 3), 0, 0);
    send_item(OP_CLEAR, 0, 0, 0);
  endtask

  function automatic int pick_weight();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 100);
    if (r < 17) return -int'($urandom_range(1, 20));
    return $urandom_range(0, 65535);
  endfunction

  task automatic test_random_graphs();
    int start;
    int n;
    int span;
    int k;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0: cfg_write(CFG_NODE_COUNT, 64);
          1: cfg_write(CFG_NODE_COUNT, 127);
          2: cfg_write(CFG_NODE_COUNT, 0);
          3: cfg_write(CFG_NODE_COUNT, 1);
          default: cfg_write(CFG_NODE_COUNT, $urandom_range(2, 9));
        endcase
        n = nodes_active();
        if ($urandom_range(0, 4) == 0) cfg_write(CFG_SOURCE, $urandom_range(0, 63));
        else cfg_write(CFG_SOURCE, $urandom_range(0, (n > 0) ? n - 1 : 0));
      end
      n = nodes_active();
      span = (n > 0) ? n - 1 : 0;
      if (pr_edges > 30 || $urandom_range(0, 4) != 0) send_item(OP_CLEAR, 0, 0, 0);
      k = (n > 16) ? $urandom_range(0, 6) : $urandom_range(0, 16);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63), pick_weight());
        else
          send_item(OP_ADD, $urandom_range(0, span), $urandom_range(0, span), pick_weight());
      end
      // occasional stray item in the middle of a sequence
      if ($urandom_range(0, 5) == 0)
        send_item(op_e'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                  pick_weight());
      send_item(OP_RUN, 0, 0, 0);
      repeat ($urandom_range(1, 5)) begin
        if ($urandom_range(0, 7) == 0) send_item(OP_TRACE, $urandom_range(0, 63), 0, 0);
        else send_item(OP_TRACE, $urandom_range(0, span), 0, 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (3) @(posedge clk_i);
    test_trace_before_run();
    test_small_graph();
    test_negative_cycle();
    test_source_cases();
    test_node_count_extremes();
    test_output_backpressure();
    test_random_graphs();
    wait_idle();
    $display("%0d items sent (%0d runs, %0d traces), %0d results checked, %0d mismatches",
             items_sent, runs_sent, traces_sent, results_seen, mismatches);
    $display("covered: empty edge store, negative cycles, node count extremes, long hold-off");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/bfsp_pkg.sv
hdl/bfsp_ram.sv
hdl/bfsp_dp.sv
hdl/bfsp_ctrl.sv
hdl/bellman_ford_shortest_path_unit.sv
tb/sv/tb_bellman_ford_shortest_path_unit.sv
